@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the IPv4 header check block.
// Needs a clk_i clock and an active-low rst_ni reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("ASSERT_ALWAYS failed");
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ASSERT_IMPLIES failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ASSERT_NEXT failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/ihcc_pkg.sv @@
// Types and constants for the IPv4 header check and classify block.
// No dependencies; imported by ipv4_header_check_classify_top.
package ihcc_pkg;

  typedef enum logic [1:0] {
    VERDICT_BAD_CSUM  = 2'd0,
    VERDICT_DELIVER   = 2'd1,
    VERDICT_FRAGMENT  = 2'd2,
    VERDICT_MALFORMED = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    CLASS_ICMP  = 2'd0,
    CLASS_TCP   = 2'd1,
    CLASS_UDP   = 2'd2,
    CLASS_OTHER = 2'd3
  } proto_class_e;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [4:0] IDX_VER_IHL  = 5'd0;
  localparam logic [4:0] IDX_TOT_LEN  = 5'd1;
  localparam logic [4:0] IDX_ID       = 5'd2;
  localparam logic [4:0] IDX_FRAG     = 5'd3;
  localparam logic [4:0] IDX_PROTO    = 5'd4;
  localparam logic [4:0] IDX_CSUM     = 5'd5;
  localparam logic [4:0] IDX_SRC_HI   = 5'd6;
  localparam logic [4:0] IDX_SRC_LO   = 5'd7;
  localparam logic [4:0] IDX_DST_HI   = 5'd8;
  localparam logic [4:0] IDX_DST_LO   = 5'd9;

  localparam logic [3:0] MIN_IHL = 4'd5;

  function automatic proto_class_e class_of(logic [7:0] proto);
    proto_class_e c;
    case (proto)
      PROTO_ICMP: c = CLASS_ICMP;
      PROTO_TCP:  c = CLASS_TCP;
      PROTO_UDP:  c = CLASS_UDP;
      default:    c = CLASS_OTHER;
    endcase
    return c;
  endfunction

endpackage

@@ design/ipv4_header_check_classify_top.sv @@
// IPv4 receive header check: verifies the header checksum and classifies the packet.
// Depends on ihcc_pkg and assert_macros.svh.
//
// Usage:
// The input channel carries one 16-bit header word per transfer, in network
// order, with start_of_packet_i high on the first word of each header. The
// output channel carries one verdict per header, with the protocol class,
// the fragment key, the header length and the payload length.
// Each accepted word goes into an input register; from it the header state
// and the checksum are updated and, on the last header word (or a malformed
// length in word 0 or 1), the verdict is loaded into the output register.
// The block takes one word every cycle while the output is not stalled.
// A stalled verdict waits in the output register; the input register still
// takes one more word, and only then is in_stall_o raised.
// Words without a preceding start are dropped, and a new start abandons a
// header in progress without a verdict.
// Reset empties both registers and leaves no header active.
`include "assert_macros.svh"

module ipv4_header_check_classify_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] header_word_i,
  input  logic        start_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [1:0]  proto_class_o,
  output logic [7:0]  protocol_o,
  output logic [15:0] packet_id_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [5:0]  header_bytes_o,
  output logic [15:0] payload_bytes_o
);
  import ihcc_pkg::*;

  logic        s1_valid_q;
  logic [15:0] s1_word_q;
  logic        s1_sop_q;

  logic        active_q, active_d;
  logic [4:0]  word_index_q, word_index_d;
  logic [4:0]  header_words_q, header_words_d;
  logic [20:0] running_sum_q, running_sum_d;
  logic [15:0] stored_csum_q, stored_csum_d;
  logic [15:0] total_length_q, total_length_d;
  logic [15:0] id_field_q, id_field_d;
  logic [13:0] flags_offset_q, flags_offset_d;
  logic [7:0]  proto_field_q, proto_field_d;
  logic [31:0] src_field_q, src_field_d;
  logic [31:0] dst_field_q, dst_field_d;

  logic         out_valid_q;
  verdict_e     verdict_q, verdict_d;
  proto_class_e class_q, class_d;
  logic [7:0]   protocol_q, protocol_d;
  logic [15:0]  packet_id_q, packet_id_d;
  logic [31:0]  src_out_q, src_out_d;
  logic [31:0]  dst_out_q, dst_out_d;
  logic [5:0]   hdr_bytes_q, hdr_bytes_d;
  logic [15:0]  payload_q, payload_d;

  logic        out_free;
  logic        fire;
  logic        take;
  logic        emit;
  logic        malformed;
  logic        last_word;
  logic [4:0]  idx;
  logic [20:0] sum_base;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] calc_csum;
  logic [5:0]  hdr_bytes;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign take       = fire && (s1_sop_q || active_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_word_q <= header_word_i;
      s1_sop_q  <= start_of_packet_i;
    end
  end

  always_comb begin
    idx            = s1_sop_q ? IDX_VER_IHL : word_index_q;
    sum_base       = s1_sop_q ? 21'd0 : running_sum_q;
    header_words_d = s1_sop_q ? 5'd0 : header_words_q;
    stored_csum_d  = stored_csum_q;
    total_length_d = total_length_q;
    id_field_d     = id_field_q;
    flags_offset_d = flags_offset_q;
    proto_field_d  = proto_field_q;
    src_field_d    = src_field_q;
    dst_field_d    = dst_field_q;
    malformed      = 1'b0;

    if (idx == IDX_CSUM) begin
      running_sum_d = sum_base;
      stored_csum_d = s1_word_q;
    end else begin
      running_sum_d = sum_base + {5'd0, s1_word_q};
    end

    case (idx)
      IDX_VER_IHL: begin
        header_words_d = {s1_word_q[11:8], 1'b0};
        malformed      = s1_word_q[11:8] < MIN_IHL;
      end
      IDX_TOT_LEN: begin
        total_length_d = s1_word_q;
        malformed      = s1_word_q < {10'd0, header_words_d, 1'b0};
      end
      IDX_ID:     id_field_d     = s1_word_q;
      IDX_FRAG:   flags_offset_d = s1_word_q[13:0];
      IDX_PROTO:  proto_field_d  = s1_word_q[7:0];
      IDX_SRC_HI: src_field_d    = {s1_word_q, src_field_q[15:0]};
      IDX_SRC_LO: src_field_d    = {src_field_q[31:16], s1_word_q};
      IDX_DST_HI: dst_field_d    = {s1_word_q, dst_field_q[15:0]};
      IDX_DST_LO: dst_field_d    = {dst_field_q[31:16], s1_word_q};
      default: ;
    endcase

    hdr_bytes = {header_words_d, 1'b0};
    last_word = ({1'b0, idx} + 6'd1) >= {1'b0, header_words_d};
    emit      = take && (malformed || last_word);

    fold1     = {12'd0, running_sum_d[20:16]} + {1'b0, running_sum_d[15:0]};
    fold2     = fold1[15:0] + {15'd0, fold1[16]};
    calc_csum = ~fold2;

    hdr_bytes_d = hdr_bytes;
    if (malformed) begin
      verdict_d   = VERDICT_MALFORMED;
      class_d     = CLASS_OTHER;
      protocol_d  = 8'd0;
      packet_id_d = 16'd0;
      src_out_d   = 32'd0;
      dst_out_d   = 32'd0;
      payload_d   = 16'd0;
    end else begin
      if (calc_csum != stored_csum_d) begin
        verdict_d = VERDICT_BAD_CSUM;
      end else if (flags_offset_d == 14'd0) begin
        verdict_d = VERDICT_DELIVER;
      end else begin
        verdict_d = VERDICT_FRAGMENT;
      end
      class_d     = class_of(proto_field_d);
      protocol_d  = proto_field_d;
      packet_id_d = id_field_d;
      src_out_d   = src_field_d;
      dst_out_d   = dst_field_d;
      payload_d   = total_length_d - {10'd0, hdr_bytes};
    end

    active_d     = !emit;
    word_index_d = idx + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= 1'b0;
      word_index_q   <= 5'd0;
      header_words_q <= 5'd0;
      running_sum_q  <= 21'd0;
    end else if (take) begin
      active_q       <= active_d;
      word_index_q   <= word_index_d;
      header_words_q <= header_words_d;
      running_sum_q  <= running_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stored_csum_q  <= stored_csum_d;
      total_length_q <= total_length_d;
      id_field_q     <= id_field_d;
      flags_offset_q <= flags_offset_d;
      proto_field_q  <= proto_field_d;
      src_field_q    <= src_field_d;
      dst_field_q    <= dst_field_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      verdict_q   <= verdict_d;
      class_q     <= class_d;
      protocol_q  <= protocol_d;
      packet_id_q <= packet_id_d;
      src_out_q   <= src_out_d;
      dst_out_q   <= dst_out_d;
      hdr_bytes_q <= hdr_bytes_d;
      payload_q   <= payload_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign proto_class_o    = class_q;
  assign protocol_o       = protocol_q;
  assign packet_id_o      = packet_id_q;
  assign source_address_o = src_out_q;
  assign dest_address_o   = dst_out_q;
  assign header_bytes_o   = hdr_bytes_q;
  assign payload_bytes_o  = payload_q;

  `ASSERT_IMPLIES(a_stall_needs_full_stage, in_stall_o, s1_valid_q && out_valid_q)
  `ASSERT_IMPLIES(a_index_within_header, active_q && word_index_q != 5'd0, word_index_q < header_words_q)
  `ASSERT_IMPLIES(a_malformed_no_payload, out_valid_q && verdict_q == VERDICT_MALFORMED, payload_q == 16'd0 && class_q == CLASS_OTHER)
  `ASSERT_IMPLIES(a_good_header_length, out_valid_q && verdict_q != VERDICT_MALFORMED, hdr_bytes_q >= 6'd20)
  `ASSERT_NEXT(a_emit_loads_output, emit, out_valid_q)

endmodule

@@ tb/sv/tb_ipv4_header_check_classify_top.sv @@
// Self-checking testbench for ipv4_header_check_classify_top: directed header words, then
// random well-formed and broken headers, each verdict checked against an in-bench predictor.
// Depends on ihcc_pkg and the RTL of the block.
module tb_ipv4_header_check_classify_top;
  import ihcc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1250;

  typedef struct packed {
    verdict_e     verdict;
    proto_class_e pclass;
    logic [7:0]   protocol;
    logic [15:0]  packet_id;
    logic [31:0]  source_address;
    logic [31:0]  dest_address;
    logic [5:0]   header_bytes;
    logic [15:0]  payload_bytes;
  } verdict_rec_t;

  typedef struct packed {
    logic [15:0] word;
    logic        sop;
    logic        is_malformed;
    logic [5:0]  hdr_bytes;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] header_word_i = 16'd0;
  logic        start_of_packet_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  verdict_o;
  logic [1:0]  proto_class_o;
  logic [7:0]  protocol_o;
  logic [15:0] packet_id_o;
  logic [31:0] source_address_o;
  logic [31:0] dest_address_o;
  logic [5:0]  header_bytes_o;
  logic [15:0] payload_bytes_o;

  verdict_rec_t verdicts_due [$];
  verdict_rec_t due;
  int           mismatches = 0;
  int           useful_words = 0;
  int           quiet_cycles = 0;
  int           rx_wait = 0;
  bit           idle_on = 1'b1;

  bit           hdr_busy = 1'b0;
  logic [4:0]   word_pos = '0;
  logic [4:0]   hdr_len_words = '0;
  logic [20:0]  csum_acc = '0;
  logic [15:0]  csum_rx = '0;
  logic [15:0]  tot_len = '0;
  logic [15:0]  ident = '0;
  logic [13:0]  frag_bits = '0;
  logic [7:0]   proto_num = '0;
  logic [31:0]  src_ip = '0;
  logic [31:0]  dst_ip = '0;

  // Rows flagged malformed carry their verdict inline; all others go through the predictor.
  stim_row_t directed_rows [22] = '{
    '{16'h1234, 1'b0, 1'b0, 6'd0},
    '{16'h4000, 1'b1, 1'b1, 6'd0},
    '{16'h4400, 1'b1, 1'b1, 6'd16},
    '{16'h4f00, 1'b1, 1'b0, 6'd0},
    '{16'h0000, 1'b0, 1'b1, 6'd60},
    '{16'h45ff, 1'b1, 1'b0, 6'd0},
    '{16'h0013, 1'b0, 1'b1, 6'd20},
    '{16'h4500, 1'b1, 1'b0, 6'd0},
    '{16'hffff, 1'b0, 1'b0, 6'd0},
    '{16'hffff, 1'b0, 1'b0, 6'd0},
    '{16'h4100, 1'b1, 1'b1, 6'd4},
    '{16'h4500, 1'b1, 1'b0, 6'd0},
    '{16'hffff, 1'b0, 1'b0, 6'd0},
    '{16'h0000, 1'b0, 1'b0, 6'd0},
    '{16'h0000, 1'b0, 1'b0, 6'd0},
    '{16'h0006, 1'b0, 1'b0, 6'd0},
    '{16'h0000, 1'b0, 1'b0, 6'd0},
    '{16'hffff, 1'b0, 1'b0, 6'd0},
    '{16'hffff, 1'b0, 1'b0, 6'd0},
    '{16'h0000, 1'b0, 1'b0, 6'd0},
    '{16'h0000, 1'b0, 1'b0, 6'd0},
    '{16'h0000, 1'b0, 1'b0, 6'd0}
  };

  ipv4_header_check_classify_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit predict_verdict(input logic [15:0] w, input logic sop,
                                         output verdict_rec_t rec);
    logic [31:0] s;
    logic [15:0] calc;
    logic [4:0]  pos;
    logic [5:0]  hdr_bytes;
    bit          bad_len;
    rec = '0;
    bad_len = 1'b0;
    if (sop) begin
      hdr_busy = 1'b1;
      word_pos = '0;
      hdr_len_words = '0;
      csum_acc = '0;
      csum_rx = '0;
      tot_len = '0;
      ident = '0;
      frag_bits = '0;
      proto_num = '0;
      src_ip = '0;
      dst_ip = '0;
    end else if (!hdr_busy) begin
      return 1'b0;
    end
    pos = word_pos;
    if (pos == IDX_CSUM) csum_rx = w;
    else csum_acc = csum_acc + w;
    case (pos)
      IDX_VER_IHL: begin
        hdr_len_words = {w[11:8], 1'b0};
        bad_len = (w[11:8] < MIN_IHL);
      end
      IDX_TOT_LEN: begin
        tot_len = w;
        bad_len = (w < {hdr_len_words, 1'b0});
      end
      IDX_ID:     ident = w;
      IDX_FRAG:   frag_bits = w[13:0];
      IDX_PROTO:  proto_num = w[7:0];
      IDX_SRC_HI: src_ip[31:16] = w;
      IDX_SRC_LO: src_ip[15:0] = w;
      IDX_DST_HI: dst_ip[31:16] = w;
      IDX_DST_LO: dst_ip[15:0] = w;
      default: ;
    endcase
    hdr_bytes = {hdr_len_words, 1'b0};
    if (bad_len) begin
      hdr_busy = 1'b0;
      rec.verdict = VERDICT_MALFORMED;
      rec.pclass = CLASS_OTHER;
      rec.header_bytes = hdr_bytes;
      return 1'b1;
    end
    if (pos + 1 < hdr_len_words) begin
      word_pos = pos + 5'd1;
      return 1'b0;
    end
    s = {11'd0, csum_acc};
    s = (s >> 16) + (s & 32'hffff);
    s = s + (s >> 16);
    calc = ~s[15:0];
    if (calc != csum_rx) rec.verdict = VERDICT_BAD_CSUM;
    else if (frag_bits == '0) rec.verdict = VERDICT_DELIVER;
    else rec.verdict = VERDICT_FRAGMENT;
    case (proto_num)
      PROTO_ICMP: rec.pclass = CLASS_ICMP;
      PROTO_TCP:  rec.pclass = CLASS_TCP;
      PROTO_UDP:  rec.pclass = CLASS_UDP;
      default:    rec.pclass = CLASS_OTHER;
    endcase
    rec.protocol = proto_num;
    rec.packet_id = ident;
    rec.source_address = src_ip;
    rec.dest_address = dst_ip;
    rec.header_bytes = hdr_bytes;
    rec.payload_bytes = tot_len - {10'd0, hdr_bytes};
    hdr_busy = 1'b0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_word(input logic [15:0] w, input logic sop, input logic typed,
                           input verdict_rec_t typed_rec);
    int           gap;
    bit           got;
    verdict_rec_t rec;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    header_word_i <= w;
    start_of_packet_i <= sop;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (sop || hdr_busy) useful_words++;
    got = predict_verdict(w, sop, rec);
    if (typed) verdicts_due.push_back(typed_rec);
    else if (got) verdicts_due.push_back(rec);
  endtask

  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (verdicts_due.size() != 0);
  endtask

  task automatic send_random_packet();
    logic [15:0] hdr [30];
    logic [31:0] s;
    int          kind;
    int          ihl;
    int          words;
    int          cut;
    int          i;
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      cut = $urandom_range(1, 3);
      for (i = 0; i < cut; i++) send_word(16'($urandom_range(0, 65535)), 1'b0, 1'b0, '0);
      return;
    end
    ihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(6, 15);
    words = ihl * 2;
    for (i = 0; i < words; i++) hdr[i] = 16'($urandom_range(0, 65535));
    hdr[0][11:8] = 4'(ihl);
    if ($urandom_range(0, 9) != 0) hdr[0][15:12] = 4'd4;
    if ($urandom_range(0, 2) == 0) hdr[1] = 16'(ihl * 4 + $urandom_range(0, 64));
    else hdr[1] = 16'($urandom_range(ihl * 4, 65535));
    if ($urandom_range(0, 1) != 0) hdr[IDX_FRAG][13:0] = '0;
    case ($urandom_range(0, 4))
      0: hdr[IDX_PROTO][7:0] = PROTO_ICMP;
      1: hdr[IDX_PROTO][7:0] = PROTO_TCP;
      2: hdr[IDX_PROTO][7:0] = PROTO_UDP;
      default: ;
    endcase
    s = 0;
    for (i = 0; i < words; i++) if (i != IDX_CSUM) s = s + hdr[i];
    s = (s >> 16) + (s & 32'hffff);
    s = s + (s >> 16);
    if ($urandom_range(0, 4) != 0) hdr[IDX_CSUM] = ~s[15:0];
    cut = words;
    if (kind >= 90) begin
      cut = $urandom_range(1, words - 1);
    end else if (kind >= 85) begin
      hdr[1] = 16'($urandom_range(0, ihl * 4 - 1));
      cut = 2 + $urandom_range(0, 2);
    end else if (kind >= 80) begin
      hdr[0][11:8] = 4'($urandom_range(0, 4));
      cut = 1 + $urandom_range(0, 2);
    end
    for (i = 0; i < cut; i++) send_word(hdr[i], i == 0, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict transfer with none expected: verdict %0d", verdict_o);
          mismatches++;
        end else begin
          due = verdicts_due.pop_front();
          check_field("verdict", due.verdict, verdict_o);
          check_field("proto_class", due.pclass, proto_class_o);
          check_field("protocol", due.protocol, protocol_o);
          check_field("packet_id", due.packet_id, packet_id_o);
          check_field("source_address", due.source_address, source_address_o);
          check_field("dest_address", due.dest_address, dest_address_o);
          check_field("header_bytes", due.header_bytes, header_bytes_o);
          check_field("payload_bytes", due.payload_bytes, payload_bytes_o);
        end
        rx_wait = idle_on ? $urandom_range(0, 9) : 0;
        out_stall_i <= (rx_wait != 0);
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_stall_i <= (rx_wait != 0);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_ipv4_header_check_classify_top: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int           r;
    int           random_goal;
    bit           drained_mid;
    verdict_rec_t typed_rec;
    drained_mid = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (r = 0; r < 22; r++) begin
      typed_rec = '{VERDICT_MALFORMED, CLASS_OTHER, 8'd0, 16'd0, 32'd0, 32'd0,
                    directed_rows[r].hdr_bytes, 16'd0};
      send_word(directed_rows[r].word, directed_rows[r].sop,
                directed_rows[r].is_malformed, typed_rec);
    end
    drain_verdicts();
    random_goal = useful_words + RANDOM_WORDS;
    while (useful_words < random_goal) begin
      if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
      send_random_packet();
      if (!drained_mid && useful_words >= random_goal - RANDOM_WORDS / 2) begin
        drain_verdicts();
        drained_mid = 1'b1;
      end
    end
    drain_verdicts();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("tb_ipv4_header_check_classify_top: done, clean");
    end else begin
      $display("tb_ipv4_header_check_classify_top: done, errors");
    end
    $finish;
  end

endmodule
